FILE: hdl/mmr_pkg.sv
// shared types, codes and constants of the matrix multiply range block
package mmr_pkg;

  localparam int unsigned MAX_DIM_DEF  = 8;
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned DIM_W        = 4;
  localparam int unsigned CFG_IDX_W    = 7;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned REG_SEL_W    = 3;
  localparam int unsigned CFG_DATA_W   = 7;

  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_ROWS_A      = 3'd0,
    REG_INNER_DIM   = 3'd1,
    REG_COLS_B      = 3'd2,
    REG_FIRST_INDEX = 3'd3,
    REG_END_INDEX   = 3'd4
  } reg_sel_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [2:0]               elem_row;
    logic [2:0]               elem_col;
    logic signed [DATA_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]         out_row;
    logic [DIM_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product_sum;
    logic                     last_of_run;
  } out_item_t;

endpackage

FILE: hdl/mmr_stream_if.sv
// valid/ready item channel with a typed payload
interface mmr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/mmr_ram.sv
// generic single write port ram with registered read
module mmr_ram import mmr_pkg::*; #(
  parameter int unsigned WIDTH = DATA_W,
  parameter int unsigned DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/matrix_multiply_range_core.sv
// top level of the integer matrix multiplier over a slice of the product
//
// Load items (write A, write B) put one 32-bit element into an on-chip store,
// and the input is ready again right after. A compute item walks the flat
// row-major product indices from first_index up to end_index (clamped to rows
// times columns, at most 64 results) and gives one result item per index:
// 1-based row, 1-based column, the dot product wrapped to 32 bits, and a mark
// on the last one. All products go through one shared 32x32 multiplier fed by
// the registered read ports of the two stores, one term per cycle. A compute
// item first finds its start position by repeated subtraction of cols_b from
// first_index, then for each result issues its terms, which pass through the
// ram read, the multiply and the accumulate registers. The input is not ready
// while a compute item is in progress; a finished result waits in the output
// register and only a full output register stalls the unit. Store entries
// that were never written read back as whatever the ram holds.
module matrix_multiply_range_core import mmr_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mmr_stream_if.sink            item_in_if,
  mmr_stream_if.source          item_out_if,
  input  logic                  cfg_we_i,
  input  logic [REG_SEL_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_ISSUE = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [DIM_W-1:0]     rows_q, inner_q, cols_q;
  logic [CFG_IDX_W-1:0] first_q, end_q;

  // run control
  logic [DIM_W-1:0]  nc_q, nc_d, nk_q, nk_d;
  logic [IDX_W-1:0]  stop_q, stop_d, idx_q, idx_d, rem_q, rem_d;
  logic [DIM_W-1:0]  row_q, row_d, col_q, col_d, k_q, k_d;
  logic [DATA_W-1:0] acc_q, acc_d, prod_q;
  logic              rd_v_q, mul_v_q;

  // output register
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;

  // effective dimensions and range of the next run
  logic [DIM_W-1:0] nr_eff, nc_eff, nk_eff;
  logic [IDX_W-1:0] total, stop_cl, span, stop_fin, first_x;
  logic             range_empty;

  // handshakes and store ports
  in_item_t          in_item;
  logic              in_fire, out_fire, issue, drain_done, load_out, last_idx;
  logic              pos_ok, we_a, we_b;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if ({1'b0, v} > (DIM_W+1)'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  assign in_item           = item_in_if.payload;
  assign item_in_if.ready  = (state_q == S_IDLE);
  assign in_fire           = item_in_if.valid && item_in_if.ready;
  assign item_out_if.valid = out_v_q;
  assign item_out_if.payload = out_q;
  assign out_fire          = out_v_q && item_out_if.ready;

  // range setup from the configuration
  assign nr_eff      = eff_dim(rows_q);
  assign nc_eff      = eff_dim(cols_q);
  assign nk_eff      = eff_dim(inner_q);
  assign total       = IDX_W'(nr_eff) * IDX_W'(nc_eff);
  assign first_x     = IDX_W'(first_q);
  assign stop_cl     = (IDX_W'(end_q) < total) ? IDX_W'(end_q) : total;
  assign range_empty = (first_x >= stop_cl);
  assign span        = stop_cl - first_x;
  assign stop_fin    = (span > IDX_W'(MAX_RESULTS)) ? first_x + IDX_W'(MAX_RESULTS) : stop_cl;

  // element writes, positions outside the store are dropped
  assign pos_ok = (int'(in_item.elem_row) < int'(MAX_DIM)) &&
                  (int'(in_item.elem_col) < int'(MAX_DIM));
  assign we_a   = in_fire && pos_ok && (in_item.cmd == CMD_WRITE_A);
  assign we_b   = in_fire && pos_ok && (in_item.cmd == CMD_WRITE_B);
  assign waddr  = AW'(int'(in_item.elem_row) * int'(MAX_DIM) + int'(in_item.elem_col));

  // term k of the current element: A(row, k) and B(k, col)
  assign raddr_a = AW'(int'(row_q) * int'(MAX_DIM) + int'(k_q));
  assign raddr_b = AW'(int'(k_q) * int'(MAX_DIM) + int'(col_q));
  assign issue   = (state_q == S_ISSUE) && (k_q != nk_q);

  assign drain_done = !rd_v_q && !mul_v_q;
  assign load_out   = (state_q == S_DRAIN) && drain_done && (!out_v_q || item_out_if.ready);
  assign last_idx   = (idx_q + IDX_W'(1)) == stop_q;

  mmr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_item.elem_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mmr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_item.elem_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    nc_d    = nc_q;
    nk_d    = nk_q;
    stop_d  = stop_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    row_d   = row_q;
    col_d   = col_q;
    k_d     = k_q;
    acc_d   = mul_v_q ? acc_q + prod_q : acc_q;
    out_v_d = out_fire ? 1'b0 : out_v_q;
    out_d   = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_item.cmd == CMD_COMPUTE) && !range_empty) begin
          nc_d    = nc_eff;
          nk_d    = nk_eff;
          stop_d  = stop_fin;
          rem_d   = first_x;
          idx_d   = first_x;
          row_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // start row and column of first_index by repeated subtraction
        if (rem_q >= IDX_W'(nc_q)) begin
          rem_d = rem_q - IDX_W'(nc_q);
          row_d = row_q + DIM_W'(1);
        end else begin
          col_d   = rem_q[DIM_W-1:0];
          k_d     = '0;
          acc_d   = '0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (issue) begin
          k_d = k_q + DIM_W'(1);
        end
        if ((nk_q == '0) || ((k_q + DIM_W'(1)) == nk_q)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (load_out) begin
          out_v_d             = 1'b1;
          out_d.out_row       = row_q + DIM_W'(1);
          out_d.out_col       = col_q + DIM_W'(1);
          out_d.product_sum   = acc_q;
          out_d.last_of_run   = last_idx;
          if (last_idx) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
            if ((col_q + DIM_W'(1)) == nc_q) begin
              col_d = '0;
              row_d = row_q + DIM_W'(1);
            end else begin
              col_d = col_q + DIM_W'(1);
            end
            k_d     = '0;
            acc_d   = '0;
            state_d = S_ISSUE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rows_q  <= DIM_W'(8);
      inner_q <= DIM_W'(8);
      cols_q  <= DIM_W'(8);
      first_q <= '0;
      end_q   <= CFG_IDX_W'(64);
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROWS_A:      rows_q  <= cfg_data_i[DIM_W-1:0];
          REG_INNER_DIM:   inner_q <= cfg_data_i[DIM_W-1:0];
          REG_COLS_B:      cols_q  <= cfg_data_i[DIM_W-1:0];
          REG_FIRST_INDEX: first_q <= cfg_data_i[CFG_IDX_W-1:0];
          REG_END_INDEX:   end_q   <= cfg_data_i[CFG_IDX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath and counters, qualified by the sequencer state
  always_ff @(posedge clk_i) begin
    nc_q   <= nc_d;
    nk_q   <= nk_d;
    stop_q <= stop_d;
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    row_q  <= row_d;
    col_q  <= col_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    prod_q <= rdata_a * rdata_b;
    out_q  <= out_d;
  end

endmodule
